// ===== sv/rsat_pkg.sv =====
`default_nettype none

package rsat_pkg;

	// Field widths fixed by the item format.
	localparam int CFG_W     = 7;
	localparam int COUNT_W   = 13;
	localparam int CFG_IDX_W = 2;

	// Largest size a 7-bit size register can express, and the size after reset.
	localparam int CFG_MAX   = 127;
	localparam int CFG_RESET = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

	// Function codes of an input word.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Corners of a query, in the order they are read.
	typedef logic [1:0] corner_t;
	localparam corner_t CORNER_HI_HI = 2'd0;
	localparam corner_t CORNER_LO_HI = 2'd1;
	localparam corner_t CORNER_HI_LO = 2'd2;
	localparam corner_t CORNER_LO_LO = 2'd3;
	localparam corner_t CORNER_FIRST = CORNER_HI_HI;
	localparam corner_t CORNER_LAST  = CORNER_LO_LO;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    in_ready;
		logic    capture;
		logic    ld_setup;
		logic    ld_commit;
		logic    q_read;
		corner_t corner;
		logic    out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		logic in_func;
		logic query_ok;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== sv/rsat_if.sv =====
`default_nettype none

// Input channel: one load cell or one rectangle query per word.
interface rsat_req_if import rsat_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic             cell_value;
	logic [CFG_W-1:0] row_first;
	logic [CFG_W-1:0] row_last;
	logic [CFG_W-1:0] col_first;
	logic [CFG_W-1:0] col_last;

	modport source (output valid, func, cell_value, row_first, row_last, col_first, col_last,
		input ready);
	modport sink (input valid, func, cell_value, row_first, row_last, col_first, col_last,
		output ready);
endinterface

// Result channel: one word per query.
interface rsat_rsp_if import rsat_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] rect_count;
	logic               bad_query;

	modport source (output valid, rect_count, bad_query, input ready);
	modport sink (input valid, rect_count, bad_query, output ready);
endinterface

// Configuration write channel.
interface rsat_cfg_if import rsat_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/rsat_ctrl.sv =====
`default_nettype none

module rsat_ctrl import rsat_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire status_t st,
	output cmd_t         cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LD_RD  = 6'b000010,
		S_LD_WR  = 6'b000100,
		S_Q_RD   = 6'b001000,
		S_Q_LAST = 6'b010000,
		S_Q_DONE = 6'b100000
	} state_t;

	state_t  state_q, state_d;
	corner_t corner_q, corner_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		corner_d = corner_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (st.in_valid) begin
					cmd.capture = 1'b1;
					corner_d    = CORNER_FIRST;
					state_d     = (st.in_func == FUNC_QUERY) ? S_Q_RD : S_LD_RD;
				end
			end
			S_LD_RD: begin
				cmd.ld_setup = 1'b1;
				state_d      = S_LD_WR;
			end
			S_LD_WR: begin
				cmd.ld_commit = 1'b1;
				state_d       = S_IDLE;
			end
			S_Q_RD: begin
				if (!st.query_ok) begin
					state_d = S_Q_DONE;
				end else begin
					cmd.q_read = 1'b1;
					cmd.corner = corner_q;
					corner_d   = corner_q + 2'd1;
					if (corner_q == CORNER_LAST) begin
						state_d = S_Q_LAST;
					end
				end
			end
			S_Q_LAST: begin
				state_d = S_Q_DONE;
			end
			S_Q_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			corner_q <= CORNER_FIRST;
		end else begin
			state_q  <= state_d;
			corner_q <= corner_d;
		end
	end

	// The load read state is always followed by the load write state.
	a_load_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LD_RD |=> state_q == S_LD_WR)
		else $error("load read not followed by write");

	// A valid query moves on once the last corner read is issued.
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_Q_RD && corner_q == CORNER_LAST && st.query_ok |=> state_q == S_Q_LAST)
		else $error("query did not finish after last corner");

	// A result is only loaded into a free output register.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("result loaded over a pending word");

endmodule

`default_nettype wire

// ===== sv/rsat_dp.sv =====
`default_nettype none

module rsat_dp import rsat_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rsat_req_if.sink   req,
	rsat_rsp_if.source rsp,
	rsat_cfg_if.sink   cfg,
	input  wire cmd_t  cmd,
	output status_t    st
);

	localparam int DEPTH   = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ROW_LIM = (MAX_ROWS > CFG_MAX) ? CFG_MAX : MAX_ROWS;
	localparam int COL_LIM = (MAX_COLS > CFG_MAX) ? CFG_MAX : MAX_COLS;
	localparam int ROW_RST = (CFG_RESET > ROW_LIM) ? ROW_LIM : CFG_RESET;
	localparam int COL_RST = (CFG_RESET > COL_LIM) ? COL_LIM : CFG_RESET;

	// A size of zero counts as one, a size above the limit as the limit.
	function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v,
		logic [CFG_W-1:0] lim);
		if (v == '0) begin
			return CFG_W'(1);
		end else if (v > lim) begin
			return lim;
		end
		return v;
	endfunction

	logic [COUNT_W-1:0] mem [DEPTH];
	logic [COUNT_W-1:0] rd_data_q;

	logic [CFG_W-1:0]   rows_q, cols_q;
	logic [CFG_W-1:0]   load_row_q, load_col_q, row_sum_q;
	logic               grid_complete_q;

	logic               cap_cell_q;
	logic [CFG_W-1:0]   cap_rf_q, cap_rl_q, cap_cf_q, cap_cl_q;

	logic               tag_valid_s1;
	corner_t            tag_corner_s1;
	logic               tag_zero_s1;
	logic [COUNT_W-1:0] acc_q;

	logic               out_valid_q;
	logic [COUNT_W-1:0] rect_count_q;
	logic               bad_q;

	logic               restart;
	logic [CFG_W-1:0]   eff_row, eff_col, eff_sum;
	logic [CFG_W-1:0]   crow, ccol, row0, col0;
	logic               corner_zero;
	logic               query_ok;
	logic               mem_rd, mem_wr;
	logic [ADDR_W-1:0]  addr;
	logic [COUNT_W-1:0] above, term;
	logic               cfg_hit;

	// Handshake and status toward the controller.
	assign req.ready   = cmd.in_ready;
	assign cfg.ready   = 1'b1;
	assign st.in_valid = req.valid;
	assign st.in_func  = req.func;
	assign st.query_ok = query_ok;
	assign st.out_free = !out_valid_q || rsp.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.rect_count = rect_count_q;
	assign rsp.bad_query  = bad_q;

	// Query bounds check against the configured size.
	assign query_ok = grid_complete_q && (cap_rf_q != '0) && (cap_rf_q <= cap_rl_q) &&
		(cap_rl_q <= rows_q) && (cap_cf_q != '0) && (cap_cf_q <= cap_cl_q) &&
		(cap_cl_q <= cols_q);

	// Load position after a possible restart of the grid.
	assign restart = grid_complete_q || (load_row_q >= rows_q) || (load_col_q >= cols_q);
	assign eff_row = restart ? '0 : load_row_q;
	assign eff_col = restart ? '0 : load_col_q;
	assign eff_sum = restart ? '0 : row_sum_q;

	// Corner selection, 1-based; a corner in row or column zero reads as zero.
	always_comb begin
		crow = cap_rl_q;
		ccol = cap_cl_q;
		case (cmd.corner)
			CORNER_HI_HI: begin
				crow = cap_rl_q;
				ccol = cap_cl_q;
			end
			CORNER_LO_HI: begin
				crow = cap_rf_q - CFG_W'(1);
				ccol = cap_cl_q;
			end
			CORNER_HI_LO: begin
				crow = cap_rl_q;
				ccol = cap_cf_q - CFG_W'(1);
			end
			CORNER_LO_LO: begin
				crow = cap_rf_q - CFG_W'(1);
				ccol = cap_cf_q - CFG_W'(1);
			end
			default: begin
				crow = cap_rl_q;
				ccol = cap_cl_q;
			end
		endcase
	end
	assign corner_zero = (crow == '0) || (ccol == '0);

	// Table address: zero-based row and column of the access.
	always_comb begin
		if (cmd.ld_setup) begin
			row0 = eff_row - CFG_W'(1);
			col0 = eff_col;
		end else if (cmd.ld_commit) begin
			row0 = load_row_q;
			col0 = load_col_q;
		end else begin
			row0 = crow - CFG_W'(1);
			col0 = ccol - CFG_W'(1);
		end
	end
	assign addr = ADDR_W'(int'(row0) * MAX_COLS + int'(col0));

	assign mem_rd = (cmd.ld_setup && (eff_row != '0)) || (cmd.q_read && !corner_zero);
	assign mem_wr = cmd.ld_commit;
	assign above  = (load_row_q == '0) ? '0 : rd_data_q;

	// Single-port table memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[addr] <= above + COUNT_W'(row_sum_q);
		end else if (mem_rd) begin
			rd_data_q <= mem[addr];
		end
	end

	// Input word capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cap_cell_q <= req.cell_value;
			cap_rf_q   <= req.row_first;
			cap_rl_q   <= req.row_last;
			cap_cf_q   <= req.col_first;
			cap_cl_q   <= req.col_last;
		end
	end

	// Configuration registers and load position; any size write restarts loading.
	assign cfg_hit = cfg.valid && ((cfg.index == REG_ROW_COUNT) || (cfg.index == REG_COL_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q          <= CFG_W'(ROW_RST);
			cols_q          <= CFG_W'(COL_RST);
			load_row_q      <= '0;
			load_col_q      <= '0;
			row_sum_q       <= '0;
			grid_complete_q <= 1'b0;
		end else if (cfg_hit) begin
			if (cfg.index == REG_ROW_COUNT) begin
				rows_q <= clamp_size(cfg.data, CFG_W'(ROW_LIM));
			end else begin
				cols_q <= clamp_size(cfg.data, CFG_W'(COL_LIM));
			end
			load_row_q      <= '0;
			load_col_q      <= '0;
			row_sum_q       <= '0;
			grid_complete_q <= 1'b0;
		end else if (cmd.ld_setup) begin
			load_row_q      <= eff_row;
			load_col_q      <= eff_col;
			row_sum_q       <= eff_sum + CFG_W'(cap_cell_q);
			grid_complete_q <= 1'b0;
		end else if (cmd.ld_commit) begin
			if (load_col_q + CFG_W'(1) >= cols_q) begin
				load_col_q <= '0;
				row_sum_q  <= '0;
				if (load_row_q + CFG_W'(1) >= rows_q) begin
					load_row_q      <= '0;
					grid_complete_q <= 1'b1;
				end else begin
					load_row_q <= load_row_q + CFG_W'(1);
				end
			end else begin
				load_col_q <= load_col_q + CFG_W'(1);
			end
		end
	end

	// Read tag follows the memory read in the next cycle, alongside the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_valid_s1 <= 1'b0;
		end else begin
			tag_valid_s1 <= cmd.q_read;
		end
	end

	always_ff @(posedge clk) begin
		tag_corner_s1 <= cmd.corner;
		tag_zero_s1   <= corner_zero;
	end

	// Four-corner accumulation: outer corners add, the two side corners subtract.
	assign term = tag_zero_s1 ? '0 : rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			acc_q <= '0;
		end else if (tag_valid_s1) begin
			if ((tag_corner_s1 == CORNER_HI_HI) || (tag_corner_s1 == CORNER_LO_LO)) begin
				acc_q <= acc_q + term;
			end else begin
				acc_q <= acc_q - term;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rect_count_q <= query_ok ? acc_q : '0;
			bad_q        <= !query_ok;
		end
	end

	// The load position stays inside the configured grid after every cell.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_commit |=> (load_row_q < rows_q) && (load_col_q < cols_q))
		else $error("load position left the grid");

	// Writing the last cell of the grid marks it complete.
	a_grid_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_commit && !cfg_hit && (load_col_q + CFG_W'(1) >= cols_q) &&
		(load_row_q + CFG_W'(1) >= rows_q) |=> grid_complete_q)
		else $error("last cell did not complete the grid");

	// Every corner read is accumulated in the following cycle.
	a_tag_follow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.q_read |=> tag_valid_s1)
		else $error("corner read lost its tag");

endmodule

`default_nettype wire

// ===== sv/rectangle_sum_table.sv =====
// Load word: a table read of the row above, then the write, then idle again to take the next word.
// Valid query: the four corners are read one per cycle through the single table port, then the
// result word is registered once the output register is free; the next word is taken after that.
// Rejected query: result registered without table reads. A pending result does not block loads.
// Reset (arst_n low) clears control, load position and sizes (64 by 64); table contents are not
// cleared and are defined only once written by the current grid.
`default_nettype none

module rectangle_sum_table import rsat_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rsat_req_if.sink   req,
	rsat_rsp_if.source rsp,
	rsat_cfg_if.sink   cfg
);

	cmd_t    cmd;
	status_t st;

	// Sequencer for loads and queries.
	rsat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// Table memory, load position, accumulator and output register.
	rsat_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.st     (st)
	);

endmodule

`default_nettype wire

// ===== tb/rect_sum_checker.sv =====
`default_nettype none

// Watches the request, result and configuration channels, keeps its own copy of
// the summed-area table, and compares every result word with the predicted count.
module rect_sum_checker import rsat_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rsat_req_if       req,
	rsat_rsp_if       rsp,
	rsat_cfg_if       cfg,
	output int        failures,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBL_W = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

	typedef struct packed {
		logic [COUNT_W-1:0] rect_count;
		logic               bad_query;
	} rect_answer_t;

	// Answers owed for accepted queries, oldest first.
	rect_answer_t due_answers[$];

	// Predicted table and load state.
	logic [COUNT_W-1:0] prefix_sums [MAX_ROWS*MAX_COLS];
	logic [CFG_W-1:0]   rows_reg;
	logic [CFG_W-1:0]   cols_reg;
	logic [CFG_W-1:0]   run_sum;
	int                 row_at;
	int                 col_at;
	bit                 grid_ready;

	// A size register of zero means one, and anything above the maximum means the maximum.
	function automatic int fit(input logic [CFG_W-1:0] v, input int lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return int'(v);
	endfunction

	// Zero-based row and column to a table slot.
	function automatic logic [TBL_W-1:0] slot(input int r, input int c);
		return TBL_W'(r * MAX_COLS + c);
	endfunction

	function automatic void restart_grid();
		run_sum = '0;
		row_at = 0;
		col_at = 0;
		grid_ready = 1'b0;
	endfunction

	// Table entry at a 1-based corner; row 0 or column 0 counts as zero.
	function automatic logic [COUNT_W-1:0] corner_sum(input int r, input int c);
		if (r == 0 || c == 0)
			return '0;
		return prefix_sums[slot(r - 1, c - 1)];
	endfunction

	// One cell in raster order: running row sum plus the entry above it.
	function automatic void accumulate_cell(input logic cell_bit);
		int                 rows;
		int                 cols;
		logic [COUNT_W-1:0] above;
		rows = fit(rows_reg, MAX_ROWS);
		cols = fit(cols_reg, MAX_COLS);
		if (grid_ready)
			restart_grid();
		if (row_at >= rows || col_at >= cols)
			restart_grid();
		run_sum = run_sum + CFG_W'(cell_bit);
		above = (row_at == 0) ? '0 : prefix_sums[slot(row_at - 1, col_at)];
		prefix_sums[slot(row_at, col_at)] = above + COUNT_W'(run_sum);
		if (col_at + 1 >= cols) begin
			col_at = 0;
			run_sum = '0;
			if (row_at + 1 >= rows) begin
				row_at = 0;
				grid_ready = 1'b1;
			end else begin
				row_at++;
			end
		end else begin
			col_at++;
		end
	endfunction

	// Four-corner difference, or a flagged zero when the query cannot be answered.
	function automatic rect_answer_t count_rectangle(input logic [CFG_W-1:0] rf,
			input logic [CFG_W-1:0] rl, input logic [CFG_W-1:0] cf,
			input logic [CFG_W-1:0] cl);
		rect_answer_t ans;
		int           rows;
		int           cols;
		rows = fit(rows_reg, MAX_ROWS);
		cols = fit(cols_reg, MAX_COLS);
		ans.rect_count = '0;
		ans.bad_query = 1'b1;
		if (grid_ready && rf >= 1 && rf <= rl && rl <= rows &&
				cf >= 1 && cf <= cl && cl <= cols) begin
			ans.rect_count = corner_sum(int'(rl), int'(cl))
				- corner_sum(int'(rf) - 1, int'(cl))
				- corner_sum(int'(rl), int'(cf) - 1)
				+ corner_sum(int'(rf) - 1, int'(cf) - 1);
			ans.bad_query = 1'b0;
		end
		return ans;
	endfunction

	// All channels are sampled at the rising edge; results leave before new queries enter.
	always @(posedge clk or negedge arst_n) begin : watch
		rect_answer_t want;
		if (!arst_n) begin
			rows_reg = CFG_W'(CFG_RESET);
			cols_reg = CFG_W'(CFG_RESET);
			restart_grid();
			due_answers.delete();
			pending = 0;
			failures = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_answers.size() == 0) begin
					$display("%0t: result word with none expected: count %0d, flag %0b",
						$time, rsp.rect_count, rsp.bad_query);
					failures++;
				end else begin
					want = due_answers.pop_front();
					if (rsp.rect_count !== want.rect_count) begin
						$display("%0t: rect_count expected %0d, got %0d",
							$time, want.rect_count, rsp.rect_count);
						failures++;
					end
					if (rsp.bad_query !== want.bad_query) begin
						$display("%0t: bad_query expected %0b, got %0b",
							$time, want.bad_query, rsp.bad_query);
						failures++;
					end
				end
			end

			// Any write to a size register throws the table away.
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_ROW_COUNT) begin
					rows_reg = cfg.data;
					restart_grid();
				end else if (cfg.index == REG_COL_COUNT) begin
					cols_reg = cfg.data;
					restart_grid();
				end
			end

			if (req.valid && req.ready) begin
				if (req.func == FUNC_LOAD)
					accumulate_cell(req.cell_value);
				else
					due_answers.push_back(count_rectangle(req.row_first, req.row_last,
						req.col_first, req.col_last));
			end
			pending = due_answers.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
	import rsat_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Words sent in the randomized part, after the directed opening.
	localparam int ITEMS = 850;
	localparam int LIMIT = 400000;
	localparam int QUIET = 12;
	localparam int MAX_SIDE = 64;
	// Index with no register behind it.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	int   snd_idle_pct = 31;
	int   rcv_idle_pct = 50;
	bit   random_part = 1'b0;
	int   random_sent = 0;
	int   cur_rows = MAX_SIDE;
	int   cur_cols = MAX_SIDE;

	rsat_req_if req_ch();
	rsat_rsp_if rsp_ch();
	rsat_cfg_if cfg_ch();

	rectangle_sum_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	rect_sum_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg      (cfg_ch),
		.failures (fail_count),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side stalls at random, at the rate of the current idling phase.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Give up if the run hangs.
	initial begin
		while (cycle_count < LIMIT)
			@(posedge clk) cycle_count++;
		$display("rectangle_sum_table: mismatch");
		$finish;
	end

	function automatic int fit(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_SIDE)
			return MAX_SIDE;
		return int'(v);
	endfunction

	// Mostly small sizes, now and then zero or something near or beyond the maximum.
	function automatic logic [CFG_W-1:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return CFG_W'($urandom_range(5, 1));
		if (r < 90)
			return CFG_W'($urandom_range(12, 6));
		if (r < 94)
			return '0;
		return CFG_W'($urandom_range(CFG_MAX, MAX_SIDE - 2));
	endfunction

	// Offers one word at a falling edge and holds it until it is taken.
	task automatic send_word(input logic fn, input logic cell_bit, input logic [CFG_W-1:0] rf,
			input logic [CFG_W-1:0] rl, input logic [CFG_W-1:0] cf,
			input logic [CFG_W-1:0] cl);
		if (!random_part || random_sent < ITEMS / 3) begin
			snd_idle_pct = 31;
			rcv_idle_pct = 50;
		end else if (random_sent < 2 * ITEMS / 3) begin
			snd_idle_pct = 50;
			rcv_idle_pct = 31;
		end else begin
			snd_idle_pct = 0;
			rcv_idle_pct = 0;
		end
		while ($urandom_range(99) < snd_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.func = fn;
		req_ch.cell_value = cell_bit;
		req_ch.row_first = rf;
		req_ch.row_last = rl;
		req_ch.col_first = cf;
		req_ch.col_last = cl;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
		if (random_part)
			random_sent++;
	endtask

	// Hold off new words until every owed answer is back and the block has settled.
	task automatic drain_results();
		req_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (QUIET) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		drain_results();
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		if (idx == REG_ROW_COUNT)
			cur_rows = fit(value);
		else if (idx == REG_COL_COUNT)
			cur_cols = fit(value);
	endtask

	// Query fields carry noise on a load; they must be ignored.
	task automatic load_cells(input int n, input int density);
		repeat (n)
			send_word(FUNC_LOAD, $urandom_range(99) < density,
				CFG_W'($urandom_range(CFG_MAX)), CFG_W'($urandom_range(CFG_MAX)),
				CFG_W'($urandom_range(CFG_MAX)), CFG_W'($urandom_range(CFG_MAX)));
	endtask

	task automatic ask(input int rf, input int rl, input int cf, input int cl);
		send_word(FUNC_QUERY, 1'($urandom_range(1)), CFG_W'(rf), CFG_W'(rl),
			CFG_W'(cf), CFG_W'(cl));
	endtask

	task automatic ask_inside();
		int rf;
		int cf;
		rf = $urandom_range(cur_rows, 1);
		cf = $urandom_range(cur_cols, 1);
		ask(rf, $urandom_range(cur_rows, rf), cf, $urandom_range(cur_cols, cf));
	endtask

	// Queries that must come back flagged (one bound past the edge, reversed or zero), or pure noise.
	task automatic ask_broken();
		int rl;
		case ($urandom_range(4))
			0: begin
				ask($urandom_range(CFG_MAX), $urandom_range(CFG_MAX),
					$urandom_range(CFG_MAX), $urandom_range(CFG_MAX));
			end
			1: begin
				ask($urandom_range(cur_rows, 1), cur_rows + 1, 1, cur_cols);
			end
			2: begin
				ask(1, cur_rows, $urandom_range(cur_cols, 1), cur_cols + 1);
			end
			3: begin
				rl = $urandom_range(cur_rows, 1);
				ask(rl + 1, rl, 1, cur_cols);
			end
			default: begin
				ask(1, cur_rows, 0, $urandom_range(cur_cols, 1));
			end
		endcase
	endtask

	initial begin : stimulus
		int cells;
		int part;
		int density;
		logic [CFG_W-1:0] r;
		logic [CFG_W-1:0] c;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_LOAD;
		req_ch.cell_value = 1'b0;
		req_ch.row_first = '0;
		req_ch.row_last = '0;
		req_ch.col_first = '0;
		req_ch.col_last = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ROW_COUNT;
		cfg_ch.data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset size is 64 by 64; queries before the grid is complete must be refused.
		ask(1, MAX_SIDE, 1, MAX_SIDE);
		load_cells(2 * MAX_SIDE, 100);
		ask(1, 1, 1, 1);
		drain_results();

		// Register extremes: 127 rows clamp to 64, zero columns count as one.
		write_reg(REG_ROW_COUNT, CFG_W'(CFG_MAX));
		write_reg(REG_COL_COUNT, '0);
		load_cells(cur_rows * cur_cols, 50);
		ask(1, MAX_SIDE, 1, 1);
		ask(MAX_SIDE, MAX_SIDE, 1, 1);
		ask(1, MAX_SIDE, 2, 2);
		ask(33, 40, 1, 1);
		ask(5, 4, 1, 1);
		ask(1, MAX_SIDE + 1, 1, 1);
		ask(1, 1, 0, 3);
		ask(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
		ask(0, 0, 0, 0);
		// A write to an index with no register leaves the table alone.
		write_reg(REG_SPARE, CFG_W'(5));
		ask(1, MAX_SIDE, 1, 1);
		// A load after a full grid starts a new one, so the table is incomplete again.
		load_cells(1, 0);
		ask(1, 1, 1, 1);
		// One full row of ones drives the running row sum to its largest value.
		write_reg(REG_ROW_COUNT, CFG_W'(1));
		write_reg(REG_COL_COUNT, CFG_W'(MAX_SIDE));
		load_cells(cur_rows * cur_cols, 100);
		ask(1, 1, 1, MAX_SIDE);
		ask(1, 1, 10, 20);
		ask(2, 2, 1, 1);

		// Random grids: mostly well-formed load-then-query sequences.
		random_part = 1'b1;
		while (random_sent < ITEMS) begin
			if ($urandom_range(3) != 0) begin
				r = pick_size();
				c = pick_size();
				if (fit(r) > 12 && fit(c) > 12)
					c = CFG_W'($urandom_range(8, 1));
				write_reg(REG_ROW_COUNT, r);
				write_reg(REG_COL_COUNT, c);
			end
			cells = cur_rows * cur_cols;
			repeat ($urandom_range(2)) ask_broken();
			density = $urandom_range(100);
			if (cells > 1 && $urandom_range(3) == 0) begin
				part = $urandom_range(cells - 1, 1);
				load_cells(part, density);
				ask_inside();
				load_cells(cells - part, density);
			end else begin
				load_cells(cells, density);
			end
			repeat ($urandom_range(8, 2)) begin
				if ($urandom_range(9) == 0)
					drain_results();
				if ($urandom_range(4) == 0)
					ask_broken();
				else
					ask_inside();
			end
		end

		req_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (QUIET) @(negedge clk);
		if (fail_count == 0)
			$display("rectangle_sum_table: match");
		else
			$display("rectangle_sum_table: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
